[sv/x86mov_pkg.sv]
`default_nettype none

package x86mov_pkg;

   typedef enum logic [1:0] {
      FORM_RM      = 2'd0,
      FORM_IMM_REG = 2'd1,
      FORM_IMM_RM  = 2'd2,
      FORM_INVALID = 2'd3
   } form_type;

   localparam logic [1:0] DISP_NONE = 2'd0;
   localparam logic [1:0] DISP_BYTE = 2'd1;
   localparam logic [1:0] DISP_WORD = 2'd2;

   localparam logic [1:0] MODE_MEM    = 2'd0;
   localparam logic [1:0] MODE_DISP8  = 2'd1;
   localparam logic [1:0] MODE_DISP16 = 2'd2;
   localparam logic [2:0] RM_DIRECT   = 3'd6;

   // decode state of the instruction in flight; also the shape of a result
   typedef struct packed {
      logic [2:0]  idx;
      form_type    form;
      logic        dir;
      logic        wide;
      logic [2:0]  reg_f;
      logic [1:0]  mode;
      logic [2:0]  rm;
      logic [1:0]  disp_cnt;
      logic [2:0]  len;
      logic [15:0] disp;
      logic [15:0] imm;
   } state_type;

endpackage

`default_nettype wire

[sv/x86_16_mov_byte_decoder.sv]
`default_nettype none

// 8086 MOV decoder fed one code byte per request. It recognizes 100010dw,
// 1011wreg and 1100011w by exact pattern, collects the ModRM byte, 0-2
// displacement bytes and 1-2 immediate bytes, and returns one decoded
// record on the request that carries the last byte of an instruction; any
// other first byte returns an invalid record of length 1. A byte is taken
// every cycle: the decode is one combinational step from the instruction
// state register into the result register, and the result register frees
// in the same cycle it is read, so req_ready drops only while a result
// waits and rsp_ready is low. A record appears in the cycle after its last byte.
module x86_16_mov_byte_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_form,
   output logic        rsp_to_register,
   output logic        rsp_wide,
   output logic [2:0]  rsp_reg_field,
   output logic [1:0]  rsp_mode_field,
   output logic [2:0]  rsp_rm_field,
   output logic [1:0]  rsp_disp_bytes,
   output logic [15:0] rsp_displacement,
   output logic [15:0] rsp_immediate,
   output logic [2:0]  rsp_length
);
   import x86mov_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type rsp_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      done;
   logic      accept;

   x86mov_step u_step (
      .st        (state_ff),
      .code_byte (req_code_byte),
      .st_next   (state_in),
      .done      (done)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         rsp_ff <= state_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_form         = rsp_ff.form;
   assign rsp_to_register  = rsp_ff.dir;
   assign rsp_wide         = rsp_ff.wide;
   assign rsp_reg_field    = rsp_ff.reg_f;
   assign rsp_mode_field   = rsp_ff.mode;
   assign rsp_rm_field     = rsp_ff.rm;
   assign rsp_disp_bytes   = rsp_ff.disp_cnt;
   assign rsp_displacement = rsp_ff.disp;
   assign rsp_immediate    = rsp_ff.imm;
   assign rsp_length       = rsp_ff.len;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.idx != 3'd0 |-> state_ff.idx < state_ff.len)
      else $error("byte index past instruction length");

   a_invalid_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.form == FORM_INVALID |-> rsp_ff.len == 3'd1)
      else $error("invalid record with length other than one");

   a_imm_reg_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.form == FORM_IMM_REG |->
         rsp_ff.dir && rsp_ff.disp_cnt == DISP_NONE && rsp_ff.disp == 16'h0000)
      else $error("imm-to-reg record carries displacement");

   a_rm_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.form == FORM_RM |->
         rsp_ff.len == 3'd2 + {1'b0, rsp_ff.disp_cnt})
      else $error("regmem record length mismatch");

   a_result_new_on_done: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> rsp_valid_ff)
      else $error("completed request produced no result");

endmodule

`default_nettype wire

[sv/x86mov_step.sv]
`default_nettype none

module x86mov_step (
   input  x86mov_pkg::state_type st,
   input  logic [7:0]            code_byte,
   output x86mov_pkg::state_type st_next,
   output logic                  done
);
   import x86mov_pkg::*;

   logic [2:0] pos;
   logic [2:0] pos_inc;
   logic [2:0] q;
   logic [2:0] iq;
   logic [1:0] dc;

   assign pos     = st.idx;
   assign pos_inc = pos + 3'd1;
   assign q       = pos - 3'd2;
   assign iq      = q - {1'b0, st.disp_cnt};

   always_comb begin
      st_next = st;
      dc      = DISP_NONE;
      if (pos == 3'd0) begin
         st_next = '0;
         case (code_byte) inside
            8'b1000_10??: begin
               st_next.form = FORM_RM;
               st_next.dir  = code_byte[1];
               st_next.wide = code_byte[0];
               st_next.len  = 3'd2;
            end
            8'b1011_????: begin
               st_next.form  = FORM_IMM_REG;
               st_next.dir   = 1'b1;
               st_next.wide  = code_byte[3];
               st_next.reg_f = code_byte[2:0];
               st_next.len   = code_byte[3] ? 3'd3 : 3'd2;
            end
            8'b1100_011?: begin
               st_next.form = FORM_IMM_RM;
               st_next.wide = code_byte[0];
               st_next.len  = code_byte[0] ? 3'd4 : 3'd3;
            end
            default: begin
               st_next.form = FORM_INVALID;
               st_next.len  = 3'd1;
            end
         endcase
      end else if (st.form == FORM_IMM_REG) begin
         if (pos == 3'd1) begin
            st_next.imm = {8'h00, code_byte};
         end else begin
            st_next.imm[15:8] = code_byte;
         end
      end else if (pos == 3'd1) begin
         st_next.mode = code_byte[7:6];
         st_next.rm   = code_byte[2:0];
         if (st.form == FORM_RM) begin
            st_next.reg_f = code_byte[5:3];
         end
         case (code_byte[7:6])
            MODE_MEM:    dc = (code_byte[2:0] == RM_DIRECT) ? DISP_WORD : DISP_NONE;
            MODE_DISP8:  dc = DISP_BYTE;
            MODE_DISP16: dc = DISP_WORD;
            default:     dc = DISP_NONE;
         endcase
         st_next.disp_cnt = dc;
         st_next.len      = st.len + {1'b0, dc};
      end else if (q < {1'b0, st.disp_cnt}) begin
         if (q == 3'd0) begin
            st_next.disp = {8'h00, code_byte};
         end else begin
            st_next.disp[15:8] = code_byte;
         end
      end else begin
         if (iq == 3'd0) begin
            st_next.imm = {8'h00, code_byte};
         end else begin
            st_next.imm[15:8] = code_byte;
         end
      end

      done        = (pos_inc >= st_next.len);
      st_next.idx = done ? 3'd0 : pos_inc;
   end

endmodule

`default_nettype wire

[sim/testbench.sv]
module testbench;
   import x86mov_pkg::*;

   localparam logic [5:0] OPC_MOV_RM      = 6'b100010;
   localparam logic [3:0] OPC_MOV_IMM_REG = 4'b1011;
   localparam logic [6:0] OPC_MOV_IMM_RM  = 7'b1100011;
   localparam logic [5:0] OPC_MOV_ACC     = 6'b101000;
   localparam logic [1:0] MODE_REGISTER   = 2'd3;
   localparam int unsigned RANDOM_BYTES   = 620;
   localparam int unsigned HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      form_type    form;
      logic        to_register;
      logic        wide;
      logic [2:0]  reg_field;
      logic [1:0]  mode_field;
      logic [2:0]  rm_field;
      logic [1:0]  disp_bytes;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [2:0]  instr_len;
   } mov_record_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_code_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_form;
   logic        rsp_to_register;
   logic        rsp_wide;
   logic [2:0]  rsp_reg_field;
   logic [1:0]  rsp_mode_field;
   logic [2:0]  rsp_rm_field;
   logic [1:0]  rsp_disp_bytes;
   logic [15:0] rsp_displacement;
   logic [15:0] rsp_immediate;
   logic [2:0]  rsp_length;

   logic [7:0]     code_stream[$];
   mov_record_type decoded_records[$];
   logic [7:0]     directed_stream[26];

   mov_record_type cur_instr;
   logic [2:0]     byte_pos;

   int unsigned error_count = 0;
   int unsigned stream_total = 0;
   int unsigned bytes_taken = 0;
   int unsigned records_checked = 0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned recv_hold = 0;
   int unsigned recv_calm = 0;
   bit          hold_off_done = 1'b0;

   x86_16_mov_byte_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_form         (rsp_form),
      .rsp_to_register  (rsp_to_register),
      .rsp_wide         (rsp_wide),
      .rsp_reg_field    (rsp_reg_field),
      .rsp_mode_field   (rsp_mode_field),
      .rsp_rm_field     (rsp_rm_field),
      .rsp_disp_bytes   (rsp_disp_bytes),
      .rsp_displacement (rsp_displacement),
      .rsp_immediate    (rsp_immediate),
      .rsp_length       (rsp_length)
   );

   function automatic int unsigned pick_gap(inout int unsigned calm_left);
      int unsigned r;
      if (calm_left != 0) begin
         calm_left = calm_left - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // little-endian byte placement; first byte zero-extends
   function automatic logic [15:0] place_byte(input logic [15:0] acc, input logic [2:0] idx,
                                              input logic [7:0] b);
      if (idx == 3'd0) return {8'h00, b};
      return {b, acc[7:0]};
   endfunction

   task automatic decode_mov_byte(input logic [7:0] b);
      logic [2:0] pos;
      logic [2:0] q;
      pos = byte_pos;
      if (pos == 3'd0) begin
         cur_instr = '0;
         if (b[7:2] == OPC_MOV_RM) begin
            cur_instr.form        = FORM_RM;
            cur_instr.to_register = b[1];
            cur_instr.wide        = b[0];
            cur_instr.instr_len   = 3'd2;
         end else if (b[7:4] == OPC_MOV_IMM_REG) begin
            cur_instr.form        = FORM_IMM_REG;
            cur_instr.to_register = 1'b1;
            cur_instr.wide        = b[3];
            cur_instr.reg_field   = b[2:0];
            cur_instr.instr_len   = b[3] ? 3'd3 : 3'd2;
         end else if (b[7:1] == OPC_MOV_IMM_RM) begin
            cur_instr.form        = FORM_IMM_RM;
            cur_instr.wide        = b[0];
            cur_instr.instr_len   = b[0] ? 3'd4 : 3'd3;
         end else begin
            cur_instr.form        = FORM_INVALID;
            cur_instr.instr_len   = 3'd1;
         end
      end else if (cur_instr.form == FORM_IMM_REG) begin
         cur_instr.immediate = place_byte(cur_instr.immediate, pos - 3'd1, b);
      end else if (pos == 3'd1) begin
         cur_instr.mode_field = b[7:6];
         cur_instr.rm_field   = b[2:0];
         if (cur_instr.form == FORM_RM) cur_instr.reg_field = b[5:3];
         if (b[7:6] == MODE_MEM && b[2:0] == RM_DIRECT) cur_instr.disp_bytes = DISP_WORD;
         else if (b[7:6] == MODE_DISP8) cur_instr.disp_bytes = DISP_BYTE;
         else if (b[7:6] == MODE_DISP16) cur_instr.disp_bytes = DISP_WORD;
         else cur_instr.disp_bytes = DISP_NONE;
         cur_instr.instr_len = cur_instr.instr_len + {1'b0, cur_instr.disp_bytes};
      end else begin
         q = pos - 3'd2;
         if (q < {1'b0, cur_instr.disp_bytes})
            cur_instr.displacement = place_byte(cur_instr.displacement, q, b);
         else
            cur_instr.immediate = place_byte(cur_instr.immediate,
                                             q - {1'b0, cur_instr.disp_bytes}, b);
      end
      pos = pos + 3'd1;
      if (pos >= cur_instr.instr_len) begin
         decoded_records.push_back(cur_instr);
         byte_pos = 3'd0;
      end else begin
         byte_pos = pos;
      end
   endtask

   task automatic check_field(input string field_name, input int unsigned expected_value,
                              input int unsigned actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0d, got %0d", field_name, expected_value, actual_value);
         error_count++;
      end
   endtask

   task automatic check_record();
      mov_record_type rec;
      if (decoded_records.size() == 0) begin
         $error("decoded record with none pending");
         error_count++;
      end else begin
         rec = decoded_records.pop_front();
         check_field("form", rec.form, rsp_form);
         check_field("to_register", rec.to_register, rsp_to_register);
         check_field("wide", rec.wide, rsp_wide);
         check_field("reg_field", rec.reg_field, rsp_reg_field);
         check_field("mode_field", rec.mode_field, rsp_mode_field);
         check_field("rm_field", rec.rm_field, rsp_rm_field);
         check_field("disp_bytes", rec.disp_bytes, rsp_disp_bytes);
         check_field("displacement", rec.displacement, rsp_displacement);
         check_field("immediate", rec.immediate, rsp_immediate);
         check_field("length", rec.instr_len, rsp_length);
      end
      records_checked++;
   endtask

   // mostly whole MOV instructions with random content, some stray bytes
   task automatic queue_random_instruction();
      logic [31:0] rnd;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      int unsigned pick;
      int unsigned tail;
      rnd  = $urandom();
      pick = $urandom_range(0, 99);
      tail = 0;
      if (pick < 30) opcode = {OPC_MOV_RM, rnd[1:0]};
      else if (pick < 50) opcode = {OPC_MOV_IMM_REG, rnd[3:0]};
      else if (pick < 75) opcode = {OPC_MOV_IMM_RM, rnd[0]};
      else if (pick < 82) opcode = {OPC_MOV_ACC, rnd[1:0]};
      else opcode = rnd[7:0];
      code_stream.push_back(opcode);
      if (pick >= 30 && pick < 50) tail = opcode[3] ? 2 : 1;
      if (pick < 30 || (pick >= 50 && pick < 75)) begin
         modrm = rnd[15:8];
         code_stream.push_back(modrm);
         if (modrm[7:6] == MODE_MEM && modrm[2:0] == RM_DIRECT) tail = 2;
         else if (modrm[7:6] == MODE_DISP8) tail = 1;
         else if (modrm[7:6] == MODE_DISP16) tail = 2;
         if (pick >= 50) tail = tail + (opcode[0] ? 2 : 1);
      end
      repeat (tail) code_stream.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      directed_stream = '{
         {OPC_MOV_RM, 2'b01}, {MODE_REGISTER, 3'd3, 3'd0},
         {OPC_MOV_RM, 2'b10}, {MODE_MEM, 3'd0, RM_DIRECT}, 8'h34, 8'h12,
         {OPC_MOV_RM, 2'b11}, {MODE_DISP8, 3'd0, 3'd7}, 8'h80,
         {OPC_MOV_IMM_REG, 1'b0, 3'd0}, 8'hFF,
         {OPC_MOV_IMM_REG, 1'b1, 3'd7}, 8'h00, 8'h80,
         {OPC_MOV_IMM_RM, 1'b0}, {MODE_MEM, 3'd7, 3'd0}, 8'h7F,
         {OPC_MOV_IMM_RM, 1'b1}, {MODE_DISP16, 3'd0, RM_DIRECT}, 8'h01, 8'h02, 8'hFF, 8'hFF,
         {OPC_MOV_ACC, 2'b00}, 8'h00, 8'hFF
      };
      foreach (directed_stream[i]) code_stream.push_back(directed_stream[i]);
      while (code_stream.size() < RANDOM_BYTES) queue_random_instruction();
      stream_total = code_stream.size();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (code_stream.size() != 0) begin
            req_valid <= 1'b1;
            req_code_byte <= code_stream.pop_front();
            send_gap = pick_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, prediction and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         cur_instr = '0;
         byte_pos = 3'd0;
      end else begin
         if (req_valid && req_ready) begin
            decode_mov_byte(req_code_byte);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) check_record();
         if (!hold_off_done && records_checked >= 100) begin
            // long stall so the result register fills and backs up the requests
            hold_off_done = 1'b1;
            recv_hold = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else if (recv_hold != 0) begin
            recv_hold = recv_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_hold = pick_gap(recv_calm);
         end
      end
   end

   initial begin
      do @(posedge clock); while (reset || stream_total == 0 || bytes_taken < stream_total);
      while (decoded_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
